// ===== rtl/cdf_pkg.sv =====
package cdf_pkg;

    localparam int MASK_COLUMNS = 64;
    localparam int MASK_W       = 64;
    localparam int COL_W        = 7;
    localparam int COL_IDX_W    = $clog2(MASK_COLUMNS);
    localparam int COL_SAT      = 64;
    localparam int RUN_MAX      = 5;
    localparam int RUN_LEN_W    = $clog2(RUN_MAX + 1);

    localparam logic [MASK_W-1:0] DROP_MASK_RESET = 64'h0000_077F_FEDF_DFCF;

    localparam logic [7:0] SEP_CHAR = 8'h2C;
    localparam logic [7:0] CHAR_N   = 8'h4E;
    localparam logic [7:0] CHAR_U   = 8'h55;
    localparam logic [7:0] CHAR_L   = 8'h4C;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             nonempty;
        logic             emitted;
    } rec_state_t;

    typedef struct packed {
        logic [RUN_MAX-1:0][7:0] bytes;
        logic [RUN_LEN_W-1:0]    len;
        logic                    bv;
        logic                    done;
    } run_t;

endpackage

// ===== rtl/cdf_step.sv =====
module cdf_step
(
    input  cdf_pkg::rec_state_t             st,
    input  logic [7:0]                      ch,
    input  logic                            last,
    input  logic [cdf_pkg::MASK_W-1:0]      mask,
    output cdf_pkg::run_t                   run,
    output cdf_pkg::rec_state_t             st_next
);
    import cdf_pkg::*;

    logic kept;
    logic null_emit;
    logic sep;

    always_comb
    begin
        kept = (st.col >= COL_W'(MASK_COLUMNS)) || !mask[st.col[COL_IDX_W-1:0]];
        null_emit = 1'b0;
        sep = 1'b0;
        run.bytes = '0;
        run.len = '0;
        run.bv = 1'b1;
        run.done = last;
        st_next = st;

        if (ch == SEP_CHAR)
        begin
            null_emit = kept && !st.nonempty;
            sep = null_emit && st.emitted;
            if (null_emit)
            begin
                if (sep)
                begin
                    run.bytes = {CHAR_L, CHAR_L, CHAR_U, CHAR_N, SEP_CHAR};
                    run.len = RUN_LEN_W'(5);
                end
                else
                begin
                    run.bytes = {8'h00, CHAR_L, CHAR_L, CHAR_U, CHAR_N};
                    run.len = RUN_LEN_W'(4);
                end
            end
            if (st.col < COL_W'(COL_SAT))
            begin
                st_next.col = st.col + COL_W'(1);
            end
            st_next.nonempty = 1'b0;
            st_next.emitted = st.emitted | null_emit;
        end
        else
        begin
            if (kept)
            begin
                sep = !st.nonempty && st.emitted;
                if (sep)
                begin
                    run.bytes[0] = SEP_CHAR;
                    run.bytes[1] = ch;
                    run.len = RUN_LEN_W'(2);
                end
                else
                begin
                    run.bytes[0] = ch;
                    run.len = RUN_LEN_W'(1);
                end
            end
            st_next.nonempty = 1'b1;
            st_next.emitted = st.emitted | kept;
        end

        // record end with nothing to send still needs a marker word
        if (last)
        begin
            if (run.len == '0)
            begin
                run.len = RUN_LEN_W'(1);
                run.bv = 1'b0;
            end
            st_next = '0;
        end
    end

endmodule

// ===== rtl/csv_column_drop_filter_unit.sv =====
// An accepted input byte is held in the input queue, then loaded into the run register that drives the output.
// Throughput: 1 input word per cycle while each byte yields at most one word and m_tready is high;
// an item yields 0 to 5 words (separator plus NULL) at one word per cycle while m_tready is high.
// A 2-entry input queue keeps s_tready registered and independent of m_tready.
// Reset (rst_n low, async): queue and output empty, column state cleared,
// drop_mask back to 0x077FFEDFDFCF.
module csv_column_drop_filter_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         drop_mask_we,
    input  logic [cdf_pkg::MASK_W-1:0]   drop_mask_wdata,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] char_in
    input  logic                         s_tlast,   // record_end
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // [7:0] char_out, [8] last_of_run
    output logic                         m_tuser,   // byte_valid
    output logic                         m_tlast    // record_done
);
    import cdf_pkg::*;

    logic [MASK_W-1:0] mask_reg;
    logic [1:0][7:0]   q_char_reg;
    logic [1:0]        q_last_reg;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    rec_state_t        st_reg;
    rec_state_t        st_next;
    run_t              run_reg;
    run_t              run_calc;
    run_t              run_next;

    logic push;
    logic pop_out;
    logic run_free;
    logic load;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign m_tvalid = (run_reg.len != '0);
    assign pop_out  = m_tvalid && m_tready;
    assign run_free = (run_reg.len == '0) || ((run_reg.len == RUN_LEN_W'(1)) && m_tready);
    assign load     = (cnt_reg != 2'd0) && run_free;

    cdf_step u_step
    (
        .st      (st_reg),
        .ch      (q_char_reg[rd_ptr_reg]),
        .last    (q_last_reg[rd_ptr_reg]),
        .mask    (mask_reg),
        .run     (run_calc),
        .st_next (st_next)
    );

    always_comb
    begin
        run_next = run_reg;
        if (load)
        begin
            run_next = run_calc;
        end
        else if (pop_out)
        begin
            run_next.bytes = run_reg.bytes >> 8;
            run_next.len = run_reg.len - RUN_LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= DROP_MASK_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            st_reg     <= '0;
            run_reg    <= '0;
        end
        else
        begin
            if (drop_mask_we)
            begin
                mask_reg <= drop_mask_wdata;
            end
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (load)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
                st_reg     <= st_next;
            end
            if (push && !load)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!push && load)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
            run_reg <= run_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_char_reg[wr_ptr_reg] <= s_tdata;
            q_last_reg[wr_ptr_reg] <= s_tlast;
        end
    end

    always_comb
    begin
        m_tdata       = '0;
        m_tdata[7:0]  = run_reg.bytes[0];
        m_tdata[8]    = (run_reg.len == RUN_LEN_W'(1));
        m_tuser       = run_reg.bv;
        m_tlast       = run_reg.done && (run_reg.len == RUN_LEN_W'(1));
    end

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[8])
        else $error("record_done without last_of_run");

    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[8])
        else $error("bare marker not closing a record");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg.len <= RUN_LEN_W'(RUN_MAX))
        else $error("run length overflow");

    a_null_start: assert property (@(posedge clk) disable iff (!rst_n)
        load && (run_calc.len > RUN_LEN_W'(2)) |->
            (run_calc.bytes[0] == SEP_CHAR) || (run_calc.bytes[0] == CHAR_N))
        else $error("long run does not start with separator or NULL");

    a_col_sat: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.col <= COL_W'(COL_SAT))
        else $error("column index past saturation");

endmodule
